@@ rtl/assert_macros.svh @@
// Assertion helpers used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, inactive while reset is asserted.
`define FLHA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("flha: same-cycle check failed");

// Next-cycle implication, inactive while reset is asserted.
`define FLHA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("flha: next-cycle check failed");

`endif

@@ rtl/flha_pkg.sv @@
`default_nettype none

package flha_pkg;

    localparam int unsigned HEAP_BYTES  = 65536;
    localparam int unsigned CHUNK_BYTES = 4096;
    localparam int unsigned WORD_BYTES  = 16;
    localparam int unsigned PAIR_BYTES  = 32;
    localparam int unsigned MIN_BLOCK   = 64;
    localparam int unsigned HEAP_WORDS  = HEAP_BYTES / WORD_BYTES;
    localparam int unsigned WIDX_W      = $clog2(HEAP_WORDS);
    localparam int unsigned LOG_HEAP    = $clog2(HEAP_BYTES);
    localparam int unsigned ADDR_W      = LOG_HEAP + 2;
    localparam int unsigned TAG_W       = 17;
    localparam int unsigned VISIT_W     = $clog2(HEAP_WORDS + 1);
    localparam int unsigned INIT_WORDS  = 8;
    localparam int unsigned INIT_W      = $clog2(INIT_WORDS);

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [TAG_W-1:0]  tag_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OOM  = 2'd2;

    localparam tag_t  USED_BIT    = tag_t'(1);
    localparam tag_t  INIT_HEAD   = tag_t'(MIN_BLOCK);
    localparam tag_t  INIT_BREAK  = tag_t'(2 * MIN_BLOCK);

    function automatic tag_t tag_len(input tag_t t);
        return t & ~tag_t'(PAIR_BYTES - 1);
    endfunction

    // Start-up layout: padding, prologue pair, one free block, epilogue.
    function automatic tag_t init_word(input logic [INIT_W-1:0] idx);
        tag_t v;
        unique case (idx)
            3'd1, 3'd2: v = tag_t'(PAIR_BYTES) | USED_BIT;
            3'd3, 3'd6: v = tag_t'(MIN_BLOCK);
            3'd7:       v = USED_BIT;
            default:    v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/flha_ram.sv @@
`default_nettype none

module flha_ram #(
    parameter int unsigned WIDTH = 17,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/free_list_heap_allocator.sv @@
// Channel  Direction  Handshake                  Payload
// s        in         s_tvalid / s_tready        tuser: op; tdata: request_bytes, block_addr
// m        out        m_tvalid / m_tready        tuser: status; tdata: result_addr
// cfg      in         cfg_valid / cfg_ready      cfg_data: heap_limit_bytes
//
// One item at a time; every heap tag and link goes through one single-port word RAM.
// A zero-size allocate touches no heap word; a free checks the block, then merges and pushes it.
// An allocate walks the free list entry by entry, and may then grow, split and merge.
// After reset the block writes the 8-word start-up layout before s_tready rises.
// A finished result waits in the output register; the next item is taken only when that
// register is empty or is read in the same cycle.
`default_nettype none

`include "assert_macros.svh"

module free_list_heap_allocator
    import flha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // request_bytes[16:0], block_addr[32:17], zeros
    input  wire logic [0:0]  s_tuser,   // op[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // result_addr[15:0]
    output logic      [1:0]  m_tuser,   // status[1:0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [16:0] cfg_data
);

    localparam int unsigned NS = 29;

    typedef enum logic [NS-1:0] {
        S_INIT  = NS'(1) << 0,
        S_IDLE  = NS'(1) << 1,
        S_FIT   = NS'(1) << 2,
        S_FITW  = NS'(1) << 3,
        S_NXTW  = NS'(1) << 4,
        S_G0    = NS'(1) << 5,
        S_G1    = NS'(1) << 6,
        S_C0    = NS'(1) << 7,
        S_C1    = NS'(1) << 8,
        S_C2    = NS'(1) << 9,
        S_C3    = NS'(1) << 10,
        S_F0    = NS'(1) << 11,
        S_F1    = NS'(1) << 12,
        S_MP    = NS'(1) << 13,
        S_MPW   = NS'(1) << 14,
        S_MNW   = NS'(1) << 15,
        S_MU1   = NS'(1) << 16,
        S_MU2   = NS'(1) << 17,
        S_MSET  = NS'(1) << 18,
        S_MPUSH = NS'(1) << 19,
        S_UA    = NS'(1) << 20,
        S_UB    = NS'(1) << 21,
        S_UC    = NS'(1) << 22,
        S_UD    = NS'(1) << 23,
        S_TA    = NS'(1) << 24,
        S_TB    = NS'(1) << 25,
        S_PA    = NS'(1) << 26,
        S_PB    = NS'(1) << 27,
        S_PC    = NS'(1) << 28
    } state_t;

    localparam addr_t WORD_A = addr_t'(WORD_BYTES);
    localparam addr_t PAIR_A = addr_t'(PAIR_BYTES);
    localparam addr_t MIN_A  = addr_t'(MIN_BLOCK);
    localparam addr_t HEAP_A = addr_t'(HEAP_BYTES);
    localparam addr_t CHNK_A = addr_t'(CHUNK_BYTES);

    state_t                  state_reg, state_next, ret_reg, ret_next;
    logic [INIT_W-1:0]       init_cnt_reg, init_cnt_next;
    tag_t                    head_reg, head_next;
    tag_t                    brk_reg, brk_next;
    tag_t                    limit_reg, limit_next;
    addr_t                   need_reg, need_next;
    logic [15:0]             baddr_reg, baddr_next;
    tag_t                    cur_reg, cur_next;
    logic [VISIT_W-1:0]      visit_reg, visit_next;
    addr_t                   b_reg, b_next;
    addr_t                   len_reg, len_next;
    addr_t                   have_reg, have_next;
    tag_t                    pt_reg, pt_next;
    tag_t                    nt_reg, nt_next;
    tag_t                    p_reg, p_next;
    tag_t                    n_reg, n_next;
    addr_t                   sa_reg, sa_next;
    addr_t                   sl_reg, sl_next;
    logic                    su_reg, su_next;
    logic                    grow_reg, grow_next;
    logic [15:0]             res_reg, res_next;
    logic [1:0]              stat_reg, stat_next;
    logic                    ov_reg, ov_next;
    logic [15:0]             oaddr_reg, oaddr_next;
    logic [1:0]              ostat_reg, ostat_next;
    logic                    oor_reg;

    logic                    acc_rd, acc_wr;
    addr_t                   acc_a;
    tag_t                    acc_d;
    logic                    acc_in;
    tag_t                    ram_q, rdata;

    logic [16:0]             in_req;
    logic [15:0]             in_addr;
    addr_t                   cur_a, fit_len, ext, lim, brk_a, plen, nlen;
    tag_t                    rd_len;
    logic                    fit_end, p_busy, n_busy, free_ok, hdr_ok, split;
    logic                    brk_ok;

    assign in_req  = s_tdata[16:0];
    assign in_addr = s_tdata[32:17];
    assign cur_a   = addr_t'(cur_reg);
    assign brk_a   = addr_t'(brk_reg);
    assign rd_len  = tag_len(rdata);
    assign fit_len = addr_t'(rd_len);
    assign fit_end = (visit_reg == VISIT_W'(HEAP_WORDS)) || (cur_reg == '0);
    assign ext     = (need_reg > CHNK_A) ? need_reg : CHNK_A;
    assign lim     = (addr_t'(limit_reg) < HEAP_A) ? addr_t'(limit_reg) : HEAP_A;
    assign plen    = addr_t'(tag_len(pt_reg));
    assign nlen    = addr_t'(tag_len(nt_reg));
    // A neighbour of size zero, such as the epilogue, never merges.
    assign p_busy  = pt_reg[0] || (plen == '0);
    assign n_busy  = nt_reg[0] || (nlen == '0);
    assign free_ok = (addr_t'(baddr_reg) >= MIN_A) && (addr_t'(baddr_reg) < brk_a)
                     && (baddr_reg[4:0] == 5'd0);
    assign hdr_ok  = rdata[0] && (fit_len >= MIN_A) && (addr_t'(baddr_reg) + fit_len <= brk_a);
    assign split   = have_reg >= need_reg + MIN_A;
    assign brk_ok  = (brk_reg[4:0] == 5'd0) && (brk_reg >= INIT_BREAK)
                     && (brk_reg <= tag_t'(HEAP_BYTES));

    // Single port to the heap store; addresses past the heap read 0 and drop writes.
    always_comb
    begin
        acc_rd = 1'b0;
        acc_wr = 1'b0;
        acc_a  = '0;
        acc_d  = '0;
        unique case (state_reg)
            S_INIT:
            begin
                acc_wr = 1'b1;
                acc_a  = addr_t'(init_cnt_reg) << 4;
                acc_d  = init_word(init_cnt_reg);
            end
            S_FIT:
            begin
                acc_rd = !fit_end;
                acc_a  = cur_a - WORD_A;
            end
            S_FITW:
            begin
                acc_rd = !rdata[0] && (need_reg > fit_len);
                acc_a  = cur_a + WORD_A;
            end
            S_G1:
            begin
                acc_wr = 1'b1;
                acc_a  = b_reg + len_reg - WORD_A;
                acc_d  = USED_BIT;
            end
            S_F0:
            begin
                acc_rd = free_ok;
                acc_a  = addr_t'(baddr_reg) - WORD_A;
            end
            S_MP:
            begin
                acc_rd = 1'b1;
                acc_a  = b_reg - PAIR_A;
            end
            S_MPW:
            begin
                acc_rd = 1'b1;
                acc_a  = b_reg + len_reg - WORD_A;
            end
            S_UA:
            begin
                acc_rd = 1'b1;
                acc_a  = sa_reg;
            end
            S_UB:
            begin
                acc_rd = 1'b1;
                acc_a  = sa_reg + WORD_A;
            end
            S_UC:
            begin
                acc_wr = (p_reg != '0);
                acc_a  = addr_t'(p_reg) + WORD_A;
                acc_d  = rdata;
            end
            S_UD:
            begin
                acc_wr = (n_reg != '0);
                acc_a  = addr_t'(n_reg);
                acc_d  = p_reg;
            end
            S_TA:
            begin
                acc_wr = 1'b1;
                acc_a  = sa_reg - WORD_A;
                acc_d  = tag_t'(sl_reg) | tag_t'(su_reg);
            end
            S_TB:
            begin
                acc_wr = 1'b1;
                acc_a  = sa_reg + sl_reg - PAIR_A;
                acc_d  = tag_t'(sl_reg) | tag_t'(su_reg);
            end
            S_PA:
            begin
                acc_wr = 1'b1;
                acc_a  = sa_reg + WORD_A;
                acc_d  = head_reg;
            end
            S_PB:
            begin
                acc_wr = (head_reg != '0);
                acc_a  = addr_t'(head_reg);
                acc_d  = tag_t'(sa_reg);
            end
            S_PC:
            begin
                acc_wr = 1'b1;
                acc_a  = sa_reg;
            end
            default:
            begin
                acc_rd = 1'b0;
            end
        endcase
    end

    assign acc_in = (acc_a >> LOG_HEAP) == '0;
    assign rdata  = oor_reg ? '0 : ram_q;

    flha_ram #(
        .WIDTH (TAG_W),
        .DEPTH (HEAP_WORDS)
    ) u_heap (
        .clk   (clk),
        .en    ((acc_rd || acc_wr) && acc_in),
        .we    (acc_wr),
        .addr  (acc_a[LOG_HEAP-1:4]),
        .wdata (acc_d),
        .rdata (ram_q)
    );

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        init_cnt_next = init_cnt_reg;
        head_next     = head_reg;
        brk_next      = brk_reg;
        limit_next    = limit_reg;
        need_next     = need_reg;
        baddr_next    = baddr_reg;
        cur_next      = cur_reg;
        visit_next    = visit_reg;
        b_next        = b_reg;
        len_next      = len_reg;
        have_next     = have_reg;
        pt_next       = pt_reg;
        nt_next       = nt_reg;
        p_next        = p_reg;
        n_next        = n_reg;
        sa_next       = sa_reg;
        sl_next       = sl_reg;
        su_next       = su_reg;
        grow_next     = grow_reg;
        res_next      = res_reg;
        stat_next     = stat_reg;
        ov_next       = ov_reg;
        oaddr_next    = oaddr_reg;
        ostat_next    = ostat_reg;

        if (cfg_valid)
        begin
            limit_next = cfg_data;
        end
        if (ov_reg && m_tready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                init_cnt_next = init_cnt_reg + 1'b1;
                if (init_cnt_reg == INIT_W'(INIT_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    baddr_next = in_addr;
                    res_next   = '0;
                    stat_next  = ST_DONE;
                    cur_next   = head_reg;
                    visit_next = '0;
                    grow_next  = 1'b0;
                    need_next  = (in_req <= 17'(PAIR_BYTES)) ? MIN_A
                                 : (((addr_t'(in_req) + addr_t'(2 * PAIR_BYTES - 1)) >> 5) << 5);
                    if (s_tuser[0] == OP_FREE)
                    begin
                        state_next = S_F0;
                    end
                    else if (in_req == '0)
                    begin
                        // A zero-size allocate touches nothing: it finishes at once.
                        stat_next  = ST_ZERO;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_FIT;
                    end
                end
            end
            S_FIT:
            begin
                state_next = fit_end ? S_G0 : S_FITW;
            end
            S_FITW:
            begin
                if (rdata[0])
                begin
                    state_next = S_G0;
                end
                else if (need_reg <= fit_len)
                begin
                    b_next     = cur_a;
                    have_next  = fit_len;
                    state_next = S_C0;
                end
                else
                begin
                    state_next = S_NXTW;
                end
            end
            S_NXTW:
            begin
                cur_next   = rdata;
                visit_next = visit_reg + 1'b1;
                state_next = S_FIT;
            end
            S_G0:
            begin
                if (brk_a + ext > lim)
                begin
                    stat_next  = ST_OOM;
                    state_next = S_IDLE;
                    ov_next    = 1'b1;
                end
                else
                begin
                    b_next     = brk_a;
                    len_next   = ext;
                    sa_next    = brk_a;
                    sl_next    = ext;
                    su_next    = 1'b0;
                    ret_next   = S_G1;
                    state_next = S_TA;
                end
            end
            S_G1:
            begin
                brk_next   = tag_t'(b_reg + len_reg);
                grow_next  = 1'b1;
                state_next = S_MP;
            end
            S_C0:
            begin
                grow_next  = 1'b0;
                res_next   = b_reg[15:0];
                sa_next    = b_reg;
                su_next    = 1'b1;
                sl_next    = split ? need_reg : have_reg;
                ret_next   = split ? S_C1 : S_C3;
                state_next = S_TA;
            end
            S_C1:
            begin
                sa_next    = b_reg;
                ret_next   = S_C2;
                state_next = S_UA;
            end
            S_C2:
            begin
                b_next     = b_reg + need_reg;
                len_next   = have_reg - need_reg;
                sa_next    = b_reg + need_reg;
                sl_next    = have_reg - need_reg;
                su_next    = 1'b0;
                ret_next   = S_MP;
                state_next = S_TA;
            end
            S_C3:
            begin
                sa_next    = b_reg;
                ret_next   = S_IDLE;
                state_next = S_UA;
            end
            S_F0:
            begin
                state_next = free_ok ? S_F1 : S_IDLE;
            end
            S_F1:
            begin
                if (hdr_ok)
                begin
                    b_next     = addr_t'(baddr_reg);
                    len_next   = fit_len;
                    sa_next    = addr_t'(baddr_reg);
                    sl_next    = fit_len;
                    su_next    = 1'b0;
                    ret_next   = S_MP;
                    state_next = S_TA;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_MP:
            begin
                state_next = S_MPW;
            end
            S_MPW:
            begin
                pt_next    = rdata;
                state_next = S_MNW;
            end
            S_MNW:
            begin
                nt_next    = rdata;
                state_next = S_MU1;
            end
            S_MU1:
            begin
                if (!p_busy)
                begin
                    sa_next    = b_reg - plen;
                    ret_next   = S_MU2;
                    state_next = S_UA;
                end
                else
                begin
                    state_next = S_MU2;
                end
            end
            S_MU2:
            begin
                if (!n_busy)
                begin
                    sa_next    = b_reg + len_reg;
                    ret_next   = S_MSET;
                    state_next = S_UA;
                end
                else
                begin
                    state_next = S_MSET;
                end
            end
            S_MSET:
            begin
                b_next     = p_busy ? b_reg : b_reg - plen;
                len_next   = len_reg + (p_busy ? '0 : plen) + (n_busy ? '0 : nlen);
                have_next  = len_reg + (p_busy ? '0 : plen) + (n_busy ? '0 : nlen);
                sa_next    = p_busy ? b_reg : b_reg - plen;
                sl_next    = len_reg + (p_busy ? '0 : plen) + (n_busy ? '0 : nlen);
                su_next    = 1'b0;
                ret_next   = S_MPUSH;
                state_next = S_TA;
            end
            S_MPUSH:
            begin
                sa_next    = b_reg;
                ret_next   = grow_reg ? S_C0 : S_IDLE;
                state_next = S_PA;
            end
            S_UA:
            begin
                state_next = S_UB;
            end
            S_UB:
            begin
                p_next     = rdata;
                state_next = S_UC;
            end
            S_UC:
            begin
                n_next = rdata;
                if (p_reg == '0)
                begin
                    head_next = rdata;
                end
                state_next = S_UD;
            end
            S_UD:
            begin
                state_next = ret_reg;
            end
            S_TA:
            begin
                state_next = S_TB;
            end
            S_TB:
            begin
                state_next = ret_reg;
            end
            S_PA:
            begin
                state_next = S_PB;
            end
            S_PB:
            begin
                state_next = S_PC;
            end
            S_PC:
            begin
                head_next  = tag_t'(sa_reg);
                state_next = ret_reg;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase

        // Every path that leaves idle returns to it once; that is where its result is posted.
        if (state_reg != S_IDLE && state_reg != S_INIT && state_next == S_IDLE)
        begin
            ov_next    = 1'b1;
            oaddr_next = (state_reg == S_G0) ? 16'd0 : res_next;
            ostat_next = stat_next;
        end
        if (state_reg == S_IDLE && state_next == S_IDLE && s_tvalid && s_tready)
        begin
            ov_next    = 1'b1;
            oaddr_next = 16'd0;
            ostat_next = ST_ZERO;
        end
    end

    // The next item is taken only when its result has room to land.
    assign s_tready  = (state_reg == S_IDLE) && (!ov_reg || m_tready);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = ov_reg;
    assign m_tdata   = oaddr_reg;
    assign m_tuser   = ostat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            ret_reg      <= S_IDLE;
            init_cnt_reg <= '0;
            head_reg     <= INIT_HEAD;
            brk_reg      <= INIT_BREAK;
            limit_reg    <= tag_t'(HEAP_BYTES);
            grow_reg     <= 1'b0;
            ov_reg       <= 1'b0;
            oor_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            init_cnt_reg <= init_cnt_next;
            head_reg     <= head_next;
            brk_reg      <= brk_next;
            limit_reg    <= limit_next;
            grow_reg     <= grow_next;
            ov_reg       <= ov_next;
            oor_reg      <= acc_rd && !acc_in;
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg  <= need_next;
        baddr_reg <= baddr_next;
        cur_reg   <= cur_next;
        visit_reg <= visit_next;
        b_reg     <= b_next;
        len_reg   <= len_next;
        have_reg  <= have_next;
        pt_reg    <= pt_next;
        nt_reg    <= nt_next;
        p_reg     <= p_next;
        n_reg     <= n_next;
        sa_reg    <= sa_next;
        sl_reg    <= sl_next;
        su_reg    <= su_next;
        res_reg   <= res_next;
        stat_reg  <= stat_next;
        oaddr_reg <= oaddr_next;
        ostat_reg <= ostat_next;
    end

    `FLHA_ASSERT_IMP(a_brk_shape, clk, rst_n, state_reg == S_IDLE, brk_ok)
    `FLHA_ASSERT_NEXT(a_one_item, clk, rst_n, s_tvalid && s_tready, !s_tready || m_tvalid)
    `FLHA_ASSERT_IMP(a_null_fail, clk, rst_n, m_tvalid && m_tuser != ST_DONE, m_tdata == 16'd0)

endmodule

`default_nettype wire

@@ tb/tb_free_list_heap_allocator.sv @@
`timescale 1ns / 1ps

module tb_free_list_heap_allocator;
    import flha_pkg::*;

    localparam int HWORDS = 4096;
    localparam int LIMIT_CYCLES = 20000000;

    typedef struct packed {
        logic        op;
        logic [16:0] req;
        logic [15:0] addr;
    } alloc_req_t;

    typedef struct packed {
        logic [15:0] addr;
        logic [1:0]  status;
    } alloc_rsp_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [39:0] s_tdata;
    logic [0:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [15:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_valid;
    logic cfg_ready;
    logic [16:0] cfg_data;

    free_list_heap_allocator i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Shadow heap of the allocator.
    int unsigned mem [HWORDS];
    int unsigned head_q;
    int unsigned brk_q;
    int unsigned limit_q;

    alloc_req_t  req_queue [$];
    alloc_rsp_t  rsp_expected [$];
    int unsigned live_blocks [$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          errors;
    int          cycles;
    bit          cfg_req;
    logic [16:0] cfg_value;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int unsigned hrd(int unsigned a);
        return ((a >> 4) < HWORDS) ? mem[a >> 4] : 0;
    endfunction

    function automatic void hwr(int unsigned a, int unsigned v);
        if ((a >> 4) < HWORDS)
            mem[a >> 4] = v;
    endfunction

    function automatic void put_tags(int unsigned b, int unsigned len, int unsigned used);
        hwr(b - 16, len | used);
        hwr(b + len - 32, len | used);
    endfunction

    function automatic void list_remove(int unsigned b);
        int unsigned p;
        int unsigned n;
        p = hrd(b);
        n = hrd(b + 16);
        if (p != 0)
            hwr(p + 16, n);
        else
            head_q = n;
        if (n != 0)
            hwr(n, p);
    endfunction

    function automatic void list_push(int unsigned b);
        hwr(b + 16, head_q);
        if (head_q != 0)
            hwr(head_q, b);
        hwr(b, 0);
        head_q = b;
    endfunction

    function automatic void coalesce(int unsigned b);
        int unsigned len;
        int unsigned pt;
        int unsigned nt;
        int unsigned plen;
        int unsigned nlen;
        bit pb;
        bit nb;
        len = hrd(b - 16) & ~32'd31;
        pt = hrd(b - 32);
        nt = hrd(b + len - 16);
        plen = pt & ~32'd31;
        nlen = nt & ~32'd31;
        pb = pt[0] || plen == 0;
        nb = nt[0] || nlen == 0;
        if (pb && !nb)
        begin
            list_remove(b + len);
            len += nlen;
        end
        else if (!pb && nb)
        begin
            b -= plen;
            list_remove(b);
            len += plen;
        end
        else if (!pb && !nb)
        begin
            list_remove(b - plen);
            list_remove(b + len);
            b -= plen;
            len += plen + nlen;
        end
        put_tags(b, len, 0);
        list_push(b);
    endfunction

    function automatic int unsigned scan_free_list(int unsigned need);
        int unsigned c;
        int unsigned t;
        c = head_q;
        for (int k = 0; k < HWORDS && c != 0; k++)
        begin
            t = hrd(c - 16);
            if (t[0])
                break;
            if (need <= (t & ~32'd31))
                return c;
            c = hrd(c + 16);
        end
        return 0;
    endfunction

    function automatic int unsigned grow_break(int unsigned ext);
        int unsigned words;
        int unsigned len;
        int unsigned lim;
        int unsigned b;
        words = ext / 16;
        if (words[0])
            words++;
        len = words * 16;
        lim = (limit_q < HWORDS * 16) ? limit_q : HWORDS * 16;
        if (len == 0 || brk_q + len > lim)
            return 0;
        b = brk_q;
        put_tags(b, len, 0);
        hwr(b + len - 16, 1);
        brk_q += len;
        coalesce(b);
        return head_q;
    endfunction

    function automatic void heap_reset();
        foreach (mem[i])
            mem[i] = 0;
        hwr(16, 33);
        hwr(32, 33);
        hwr(48, 64);
        hwr(96, 64);
        hwr(112, 1);
        head_q = 64;
        brk_q = 128;
        limit_q = 65536;
    endfunction

    function automatic alloc_rsp_t heap_step(alloc_req_t r);
        alloc_rsp_t o;
        int unsigned need;
        int unsigned b;
        int unsigned have;
        int unsigned t;
        int unsigned len;
        o.addr = '0;
        o.status = ST_DONE;
        if (r.op == OP_ALLOC)
        begin
            if (r.req == 0)
                o.status = ST_ZERO;
            else
            begin
                need = (r.req <= 32) ? 64 : 32 * ((r.req + 63) / 32);
                b = scan_free_list(need);
                if (b == 0)
                    b = grow_break((need > CHUNK_BYTES) ? need : CHUNK_BYTES);
                if (b == 0)
                    o.status = ST_OOM;
                else
                begin
                    have = hrd(b - 16) & ~32'd31;
                    if (have >= need + 64)
                    begin
                        put_tags(b, need, 1);
                        list_remove(b);
                        put_tags(b + need, have - need, 0);
                        coalesce(b + need);
                    end
                    else
                    begin
                        put_tags(b, have, 1);
                        list_remove(b);
                    end
                    o.addr = b[15:0];
                end
            end
        end
        else if (r.addr >= 64 && r.addr < brk_q && r.addr[4:0] == 0)
        begin
            t = hrd(r.addr - 16);
            len = t & ~32'd31;
            if (t[0] && len >= 64 && r.addr + len <= brk_q)
            begin
                put_tags(r.addr, len, 0);
                coalesce(r.addr);
            end
        end
        return o;
    endfunction

    // Bad frees only target addresses that fail the range or alignment check (below the heap start,
    // misaligned or past the break), so they are rejected before any heap read.
    function automatic alloc_req_t pick_item();
        alloc_req_t r;
        int unsigned sel;
        int unsigned idx;
        r = '0;
        sel = $urandom_range(0, 99);
        if (sel < 50 || live_blocks.size() == 0)
        begin
            r.op = OP_ALLOC;
            case ($urandom_range(0, 9))
                0: r.req = 0;
                1: r.req = $urandom_range(4097, 65536);
                2, 3: r.req = $urandom_range(200, 2000);
                default: r.req = $urandom_range(1, 200);
            endcase
        end
        else if (sel < 92)
        begin
            r.op = OP_FREE;
            idx = $urandom_range(0, live_blocks.size() - 1);
            r.addr = live_blocks[idx];
            live_blocks.delete(idx);
        end
        else
        begin
            r.op = OP_FREE;
            case ($urandom_range(0, 2))
                0: r.addr = $urandom_range(0, 63);
                1: r.addr = $urandom_range(0, 65535) | 16'h0001;
                default: r.addr = (brk_q <= 32'hFFE0) ? 16'hFFE0 : 16'h0020;
            endcase
        end
        return r;
    endfunction

    // Predicts results as items are queued, tracking which addresses are live.
    task automatic queue_item(alloc_req_t r);
        alloc_rsp_t o;
        o = heap_step(r);
        if (r.op == OP_ALLOC && o.addr != 0)
            live_blocks.push_back(o.addr);
        req_queue.push_back(r);
        rsp_expected.push_back(o);
    endtask

    task automatic drain();
        while (req_queue.size() != 0 || rsp_expected.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_limit(logic [16:0] v);
        cfg_value = v;
        cfg_req = 1'b1;
        @(posedge clk);
        while (cfg_req)
            @(posedge clk);
        limit_q = v;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            m_tready <= 1'b0;
            cfg_valid <= 1'b0;
            cfg_data <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_valid <= 1'b0;
                cfg_req <= 1'b0;
            end
            else if (cfg_req && !cfg_valid)
            begin
                cfg_valid <= 1'b1;
                cfg_data <= cfg_value;
            end
            // The front of the queue is the item on the bus until it is accepted.
            if (!s_tvalid || s_tready)
            begin
                if (s_tvalid)
                    void'(req_queue.pop_front());
                if (req_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {7'd0, req_queue[0].addr, req_queue[0].req};
                    s_tuser <= req_queue[0].op;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (rsp_expected.size() == 0)
            begin
                $error("unexpected result: result_addr %0d status %0d", m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                if (m_tdata !== rsp_expected[0].addr)
                begin
                    $error("result_addr expected %0d actual %0d", rsp_expected[0].addr, m_tdata);
                    errors++;
                end
                if (m_tuser !== rsp_expected[0].status)
                begin
                    $error("status expected %0d actual %0d", rsp_expected[0].status, m_tuser);
                    errors++;
                end
                void'(rsp_expected.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("free_list_heap_allocator verification failed");
            $finish;
        end
    end

    initial
    begin
        alloc_req_t r;
        logic [16:0] limits [5];
        errors = 0;
        cycles = 0;
        cfg_req = 1'b0;
        cfg_value = '0;
        send_idle_pct = 6;
        recv_idle_pct = 82;
        limits = '{17'd256, 17'd65536, 17'd8192, 17'd131071, 17'd20000};
        rst_n = 1'b0;
        heap_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: zero size, smallest and largest requests, growth,
        // splitting, merging on both sides, double free and bad frees.
        r = '0; queue_item(r);
        r.req = 1; queue_item(r);
        r.req = 32; queue_item(r);
        r.req = 33; queue_item(r);
        r.req = 5000; queue_item(r);
        r.req = 17'h1FFFF; queue_item(r);
        r.req = 65536; queue_item(r);
        r.req = 100; queue_item(r);
        for (int i = 0; i < 4; i++)
        begin
            r = '0;
            r.op = OP_FREE;
            r.addr = live_blocks[0];
            live_blocks.delete(0);
            queue_item(r);
            if (i == 0)
                queue_item(r);
        end
        r = '0; r.op = OP_FREE;
        r.addr = 0; queue_item(r);
        r.addr = 16'hFFFF; queue_item(r);
        r.addr = 16'h0041; queue_item(r);
        r.addr = 32; queue_item(r);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_limit(limits[ph]);
            if (ph == 2)
            begin
                send_idle_pct = 82;
                recv_idle_pct = 6;
            end
            if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < 330; i++)
                queue_item(pick_item());
            drain();
        end

        if (errors == 0)
            $display("free_list_heap_allocator verification clean");
        else
            $display("free_list_heap_allocator verification failed");
        $finish;
    end

endmodule
